### hw/rtl/dpf_pkg.sv
// Package for the deduplicating packet FIFO.
// Holds sizes, command codes, stored-entry and result types, and pointer and limit helpers.
// No dependencies.
package dpf_pkg;

  localparam int DEPTH     = 64;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W     = $clog2(DEPTH + 1);
  localparam int CFG_W     = 7;
  localparam int CNT_W     = 7;
  localparam int CFG_RESET = 64;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FWD   = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
  } entry_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
    cnt_t        cnt;
  } res_t;

  // Add two ring indexes, wrapping at DEPTH.
  function automatic addr_t wrap_add(addr_t a, addr_t b);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ADDR_W + 1)'(DEPTH)) s = s - (ADDR_W + 1)'(DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  // Clamp the configured limit to 1..DEPTH.
  function automatic occ_t eff_limit(cfg_t v);
    occ_t r;
    if (v == '0) r = occ_t'(1);
    else if (32'(v) > DEPTH) r = occ_t'(DEPTH);
    else r = occ_t'(v);
    return r;
  endfunction

endpackage

### hw/rtl/dpf_req_if.sv
// Request channel of the packet FIFO: valid/ready plus command word.
// Depends on nothing.
interface dpf_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] src_addr;
  logic [15:0] destination;
  logic [31:0] timestamp;
  logic [31:0] start_time;
  logic [31:0] end_time;

  modport source (output valid, cmd, src_addr, destination, timestamp, start_time, end_time,
                  input ready);
  modport sink   (input valid, cmd, src_addr, destination, timestamp, start_time, end_time,
                  output ready);
endinterface

### hw/rtl/dpf_rsp_if.sv
// Response channel of the packet FIFO: valid/ready plus result word.
// Depends on nothing.
interface dpf_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [15:0] out_source;
  logic [15:0] out_destination;
  logic [31:0] out_timestamp;
  logic [6:0]  match_count;

  modport source (output valid, ok, out_source, out_destination, out_timestamp, match_count,
                  input ready);
  modport sink   (input valid, ok, out_source, out_destination, out_timestamp, match_count,
                  output ready);
endinterface

### hw/rtl/dedup_packet_fifo_with_range_count.sv
// Deduplicating packet FIFO with range count. A command word is taken when the block is idle;
// add and count read every queued entry from the entry RAM, one per cycle, while forward
// reads at most the oldest entry and an unused command reads none. The entry RAM has a single
// read port. The result sits in an output register, so the next command can be taken while it
// waits; a second finished result holds the sequencer until that register drains. Reset clears
// no memory and needs no clearing pass.
// Depends on dpf_pkg, dpf_req_if, dpf_rsp_if and dpf_engine.
module dedup_packet_fifo_with_range_count (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  dpf_pkg::cfg_t cfg_wr_data,
  dpf_req_if.sink      req,
  dpf_rsp_if.source    rsp
);

  dpf_pkg::cfg_t limit_reg;
  dpf_pkg::occ_t lim;
  logic          res_valid;
  logic          res_ready;
  dpf_pkg::res_t res;
  logic          out_valid;
  dpf_pkg::res_t out_q;

  // Hold the limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit_reg <= dpf_pkg::cfg_t'(dpf_pkg::CFG_RESET);
    end else if (cfg_wr_en) begin
      limit_reg <= cfg_wr_data;
    end
  end

  assign lim = dpf_pkg::eff_limit(limit_reg);

  dpf_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .lim       (lim),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load a finished result when the slot is free or drains
  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign rsp.valid           = out_valid;
  assign rsp.ok              = out_q.ok;
  assign rsp.out_source      = out_q.src;
  assign rsp.out_destination = out_q.dst;
  assign rsp.out_timestamp   = out_q.ts;
  assign rsp.match_count     = out_q.cnt;

endmodule

### hw/rtl/dpf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

### hw/rtl/dpf_engine.sv
// Sequencer of the packet FIFO: ring pointers, entry scan and commit.
// Depends on dpf_pkg, dpf_req_if and dpf_ram.
module dpf_engine (
  input  logic              clk,
  input  logic              rst,
  dpf_req_if.sink           req,
  input  dpf_pkg::occ_t     lim,
  output logic              res_valid,
  input  logic              res_ready,
  output dpf_pkg::res_t     res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t         state;
  dpf_pkg::cmd_t  cmd_q;
  logic [15:0]    src_q;
  logic [15:0]    dst_q;
  logic [31:0]    ts_q;
  logic [31:0]    lo_q;
  logic [31:0]    hi_q;
  dpf_pkg::addr_t head;
  dpf_pkg::addr_t tail;
  dpf_pkg::occ_t  occ;
  dpf_pkg::occ_t  idx;
  dpf_pkg::occ_t  scan_len;
  logic           rvalid;
  logic           hit;
  dpf_pkg::cnt_t  cnt;
  dpf_pkg::entry_t fwd;

  logic            rd_en;
  dpf_pkg::addr_t  rd_addr;
  dpf_pkg::entry_t rd_data;
  logic            wr_en;
  dpf_pkg::entry_t wr_data;
  logic            full_match;
  logic            range_match;
  logic            commit;
  logic            add_ok;
  dpf_pkg::occ_t   drop;
  dpf_pkg::addr_t  drop_a;
  dpf_pkg::occ_t   scan_len_next;

  // Entry store, one word per slot
  dpf_ram #(
    .WIDTH ($bits(dpf_pkg::entry_t)),
    .DEPTH (dpf_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Issue one read per cycle, oldest entry first
  assign rd_en   = (state == ST_SCAN) && (idx < scan_len);
  assign rd_addr = dpf_pkg::wrap_add(head, dpf_pkg::addr_t'(idx));

  // Compare the word returned by the RAM
  assign full_match  = (rd_data.src == src_q) && (rd_data.dst == dst_q) &&
                       (rd_data.ts == ts_q);
  assign range_match = (rd_data.dst == dst_q) && (rd_data.ts >= lo_q) &&
                       (rd_data.ts <= hi_q);

  // Scan length per command
  always_comb begin
    unique case (dpf_pkg::cmd_t'(req.cmd))
      dpf_pkg::CMD_ADD:   scan_len_next = occ;
      dpf_pkg::CMD_COUNT: scan_len_next = occ;
      dpf_pkg::CMD_FWD:   scan_len_next = (occ != '0) ? dpf_pkg::occ_t'(1) : '0;
      default:            scan_len_next = '0;
    endcase
  end

  // Commit: evict down to one below the limit, then append
  assign commit  = (state == ST_DONE) && res_ready;
  assign add_ok  = (cmd_q == dpf_pkg::CMD_ADD) && !hit;
  assign drop    = (occ >= lim) ? (occ - lim + dpf_pkg::occ_t'(1)) : '0;
  assign drop_a  = (32'(drop) == dpf_pkg::DEPTH) ? '0 : dpf_pkg::addr_t'(drop);
  assign wr_en   = commit && add_ok;
  assign wr_data = '{src: src_q, dst: dst_q, ts: ts_q};

  // Result word
  assign res_valid = (state == ST_DONE);
  always_comb begin
    res = '0;
    unique case (cmd_q)
      dpf_pkg::CMD_ADD:   res.ok = !hit;
      dpf_pkg::CMD_FWD: begin
        if (occ != '0) begin
          res.ok  = 1'b1;
          res.src = fwd.src;
          res.dst = fwd.dst;
          res.ts  = fwd.ts;
        end
      end
      dpf_pkg::CMD_COUNT: res.cnt = cnt;
      default:            res = '0;
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  // Control state, pointers and scan registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      head   <= '0;
      tail   <= '0;
      occ    <= '0;
      rvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cmd_q    <= dpf_pkg::cmd_t'(req.cmd);
            src_q    <= req.src_addr;
            dst_q    <= req.destination;
            ts_q     <= req.timestamp;
            lo_q     <= req.start_time;
            hi_q     <= req.end_time;
            scan_len <= scan_len_next;
            idx      <= '0;
            hit      <= 1'b0;
            cnt      <= '0;
            rvalid   <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rvalid <= rd_en;
          if (rd_en) idx <= idx + dpf_pkg::occ_t'(1);
          if (rvalid) begin
            fwd <= rd_data;
            if (cmd_q == dpf_pkg::CMD_ADD && full_match) hit <= 1'b1;
            if (cmd_q == dpf_pkg::CMD_COUNT && range_match) cnt <= cnt + dpf_pkg::cnt_t'(1);
          end
          if (!rd_en && !rvalid) state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
            if (add_ok) begin
              head <= dpf_pkg::wrap_add(head, drop_a);
              tail <= dpf_pkg::wrap_add(tail, dpf_pkg::addr_t'(1));
              occ  <= occ - drop + dpf_pkg::occ_t'(1);
            end else if (cmd_q == dpf_pkg::CMD_FWD && occ != '0) begin
              head <= dpf_pkg::wrap_add(head, dpf_pkg::addr_t'(1));
              occ  <= occ - dpf_pkg::occ_t'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // Occupancy stays within the ring
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= dpf_pkg::DEPTH)
    else $error("occupancy above depth");

  // Tail always sits occupancy slots past head
  a_ring_consistent: assert property (@(posedge clk) disable iff (rst)
    (32'(occ) == dpf_pkg::DEPTH) ? (tail == head)
      : (dpf_pkg::wrap_add(head, dpf_pkg::addr_t'(occ)) == tail))
    else $error("head, tail and occupancy disagree");

  // An accepted add leaves occupancy within the limit
  a_add_limit: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (occ <= $past(lim)))
    else $error("add left occupancy above limit");

  // No RAM read while a write commits
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("read overlaps commit write");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for dedup_packet_fifo_with_range_count.
// Drives command words on dpf_req_if and checks each reply word on dpf_rsp_if.
// Depends on dpf_pkg, dpf_req_if, dpf_rsp_if and the block itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 12;
  localparam int TIMEOUT_CYCLES = 700000;
  localparam int DRAIN_CYCLES   = dpf_pkg::DEPTH + 8;
  localparam int HOLDOFF_AT     = 400;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int REPORT_MAX     = 10;

  // Shadow of the packet queue: predicts one reply word per command word and checks it.
  class dedup_fifo_shadow;
    dpf_pkg::entry_t queued[$];
    dpf_pkg::res_t   replies_due[$];
    dpf_pkg::cfg_t   limit_reg;
    int     mismatches;
    int     replies_seen;
    int     added, refused, dropped, forwarded, fwd_empty, counted, unused;

    function new();
      limit_reg = dpf_pkg::cfg_t'(dpf_pkg::CFG_RESET);
    endfunction

    function void set_limit(dpf_pkg::cfg_t v);
      limit_reg = v;
    endfunction

    // Apply one accepted command word and queue the reply it must produce.
    function void take_command(dpf_pkg::cmd_t c, logic [15:0] s, logic [15:0] d,
                               logic [31:0] t, logic [31:0] lo, logic [31:0] hi);
      dpf_pkg::res_t   r;
      dpf_pkg::entry_t e;
      bit     dup;
      int     n;
      int     lim;
      r   = '0;
      e   = '{src: s, dst: d, ts: t};
      dup = 1'b0;
      n   = 0;
      // zero acts as one, anything above the depth acts as the depth
      lim = int'(limit_reg);
      if (lim < 1) lim = 1;
      if (lim > dpf_pkg::DEPTH) lim = dpf_pkg::DEPTH;
      case (c)
        dpf_pkg::CMD_ADD: begin
          // the duplicate test sees the oldest entry even when it is about to go
          foreach (queued[i]) if (queued[i] == e) dup = 1'b1;
          if (dup) begin
            refused++;
          end else begin
            while (queued.size() >= lim) begin
              queued.delete(0);
              dropped++;
            end
            queued.insert(queued.size(), e);
            r.ok = 1'b1;
            added++;
          end
        end
        dpf_pkg::CMD_FWD: begin
          if (queued.size() > 0) begin
            e     = queued[0];
            queued.delete(0);
            r.ok  = 1'b1;
            r.src = e.src;
            r.dst = e.dst;
            r.ts  = e.ts;
            forwarded++;
          end else begin
            fwd_empty++;
          end
        end
        dpf_pkg::CMD_COUNT: begin
          foreach (queued[i])
            if (queued[i].dst == d && queued[i].ts >= lo && queued[i].ts <= hi) n++;
          r.cnt = dpf_pkg::cnt_t'(n);
          counted++;
        end
        default: begin
          unused++;
        end
      endcase
      replies_due.insert(replies_due.size(), r);
    endfunction

    // Compare one reply word with the oldest prediction.
    function void check_reply(dpf_pkg::res_t got);
      dpf_pkg::res_t want;
      bit   bad;
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("ERROR at %0t: reply word with no command waiting for it", $time);
        return;
      end
      want = replies_due[0];
      replies_due.delete(0);
      bad  = (got.ok !== want.ok) || (got.src !== want.src) || (got.dst !== want.dst) ||
             (got.ts !== want.ts) || (got.cnt !== want.cnt);
      if (bad) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("ERROR at %0t: reply %0d expected ok=%0b src=%h dst=%h ts=%h cnt=%0d",
                   $time, replies_seen, want.ok, want.src, want.dst, want.ts, want.cnt);
          $display("       got                  ok=%0b src=%h dst=%h ts=%h cnt=%0d",
                   got.ok, got.src, got.dst, got.ts, got.cnt);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  dpf_pkg::cfg_t cfg_wr_data;
  bit   steady;
  int   limit_writes;

  dedup_fifo_shadow shadow = new();

  dpf_req_if req_ch ();
  dpf_rsp_if rsp_ch ();

  dedup_packet_fifo_with_range_count dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout after %0d cycles", TIMEOUT_CYCLES);
    $display("Mismatches found");
    $finish;
  end

  // Small address pool so duplicates and count hits are common.
  function automatic logic [15:0] pick_addr();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(0, 3));
    if (r < 75) return r[0] ? 16'hFFFF : 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic logic [31:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 32'($urandom_range(0, 5));
    if (r < 75) return r[0] ? 32'hFFFF_FFFF : 32'h8000_0000;
    return 32'($urandom);
  endfunction

  // Offer one command word and hold it until the block takes it.
  task automatic send_word(input dpf_pkg::cmd_t c, input logic [15:0] s,
                           input logic [15:0] d, input logic [31:0] t,
                           input logic [31:0] lo, input logic [31:0] hi);
    if (!steady && $urandom_range(0, 99) < 20) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= c;
    req_ch.src_addr    <= s;
    req_ch.destination <= d;
    req_ch.timestamp   <= t;
    req_ch.start_time  <= lo;
    req_ch.end_time    <= hi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    shadow.take_command(c, s, d, t, lo, hi);
  endtask

  // Drop valid and wait until every reply word has come back.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (shadow.replies_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the limit register while the block is idle.
  task automatic write_limit(input int unsigned v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dpf_pkg::cfg_t'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow.set_limit(dpf_pkg::cfg_t'(v));
    limit_writes++;
  endtask

  task automatic random_words(input int n, input int add_pct, input int fwd_pct,
                              input int cnt_pct);
    int          r;
    logic [31:0] lo;
    logic [31:0] hi;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < add_pct) begin
        send_word(dpf_pkg::CMD_ADD, pick_addr(), pick_addr(), pick_time(), $urandom,
                  $urandom);
      end else if (r < add_pct + fwd_pct) begin
        send_word(dpf_pkg::CMD_FWD, 16'($urandom), 16'($urandom), $urandom, $urandom,
                  $urandom);
      end else if (r < add_pct + fwd_pct + cnt_pct) begin
        if ($urandom_range(0, 9) == 0) begin
          lo = '0;
          hi = '1;
        end else begin
          lo = pick_time();
          hi = pick_time();
        end
        send_word(dpf_pkg::CMD_COUNT, 16'($urandom), pick_addr(), $urandom, lo, hi);
      end else begin
        send_word(dpf_pkg::CMD_NONE, 16'($urandom), 16'($urandom), $urandom, $urandom,
                  $urandom);
      end
    end
  endtask

  // Reply side: check each word, stall at random, and hold off once for a long stretch.
  initial begin : reply_sink
    dpf_pkg::res_t got;
    int   hold_left;
    bit   hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.ok  = rsp_ch.ok;
        got.src = rsp_ch.out_source;
        got.dst = rsp_ch.out_destination;
        got.ts  = rsp_ch.out_timestamp;
        got.cnt = rsp_ch.match_count;
        shadow.check_reply(got);
      end
      if (!hold_done && shadow.replies_seen >= HOLDOFF_AT) begin
        hold_done = 1'b1;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
      end
    end
  end

  initial begin : stimulus
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= dpf_pkg::CMD_NONE;
    req_ch.src_addr    <= '0;
    req_ch.destination <= '0;
    req_ch.timestamp   <= '0;
    req_ch.start_time  <= '0;
    req_ch.end_time    <= '0;
    steady       = 1'b0;
    limit_writes = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, duplicates, empty queue, inverted range, unused command
    write_limit(64);
    send_word(dpf_pkg::CMD_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_word(dpf_pkg::CMD_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h0000, 16'h0000, 32'h1, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h0001, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_word(dpf_pkg::CMD_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h1, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0000, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(dpf_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_word(dpf_pkg::CMD_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0000, 16'hFFFF, 32'h0, 32'h0, 32'hFFFF_FFFE);
    repeat (5) send_word(dpf_pkg::CMD_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);

    // Limit of one: duplicate of the only (oldest) entry is refused, a new one evicts it
    write_limit(1);
    send_word(dpf_pkg::CMD_ADD, 16'h1234, 16'h5678, 32'hDEAD_BEEF, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h1234, 16'h5678, 32'hDEAD_BEEF, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_ADD, 16'h1234, 16'h5678, 32'hDEAD_BEF0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_COUNT, 16'h0000, 16'h5678, 32'h0, 32'hDEAD_BEEF, 32'hDEAD_BEF0);
    send_word(dpf_pkg::CMD_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    send_word(dpf_pkg::CMD_FWD, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0);
    random_words(100, 45, 25, 25);

    // Zero acts as one
    write_limit(0);
    random_words(100, 45, 25, 25);

    // Above the depth acts as the depth; fill up, hold-off lands here
    write_limit(127);
    random_words(500, 60, 10, 25);

    // Lower the limit under the current occupancy without draining the queue
    write_limit(3);
    random_words(150, 50, 20, 25);

    // Steady stretch with no idling on either side
    write_limit(100);
    steady = 1'b1;
    random_words(300, 55, 15, 25);
    steady = 1'b0;

    write_limit(17);
    random_words(250, 50, 20, 25);

    write_limit(64);
    random_words(250, 55, 15, 25);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run: %0d replies checked, %0d adds stored, %0d duplicates refused, %0d evicted",
             shadow.replies_seen, shadow.added, shadow.refused, shadow.dropped);
    $display("     %0d forwarded, %0d forwards on empty, %0d range counts, %0d unused",
             shadow.forwarded, shadow.fwd_empty, shadow.counted, shadow.unused);
    $display("     %0d limit writes", limit_writes);
    if (shadow.mismatches == 0 && shadow.replies_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### dedup_packet_fifo_with_range_count.f
hw/rtl/dpf_pkg.sv
hw/rtl/dpf_req_if.sv
hw/rtl/dpf_rsp_if.sv
hw/rtl/dpf_ram.sv
hw/rtl/dpf_engine.sv
hw/rtl/dedup_packet_fifo_with_range_count.sv
tb/tb.sv
